// ----- src/circle_box_collision_resolve_top_assert.svh -----
// Assertion macros shared by the circle/box resolver RTL.
// Included by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef CIRCLE_BOX_COLLISION_RESOLVE_TOP_ASSERT_SVH
`define CIRCLE_BOX_COLLISION_RESOLVE_TOP_ASSERT_SVH

// same-cycle implication
`define CBCR_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: property violated");

// next-cycle implication
`define CBCR_ASSERT_NX(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: property violated");

`endif

// ----- src/cbcr_pkg.sv -----
// Shared types and constants for the circle/box collision resolver.
// Used by the controller, datapath and top level.
package cbcr_pkg;

  localparam int RADIUS_W   = 23;
  localparam int TOL_W      = 16;
  localparam int EPS_W      = 25;
  localparam int DXW        = 26;  // offset width once the box test has passed
  localparam int MW         = 28;  // multiplier operand width
  localparam int PRW        = 2 * MW;
  localparam int DW         = 52;  // squared distance width
  localparam int SQW        = 26;  // integer root width
  localparam int PSW        = 27;  // push width
  localparam int QW         = 28;  // quotient width
  localparam int NW         = 56;  // dividend width
  localparam int SQRT_ITERS = 26;
  localparam int DIV_ITERS  = QW;
  localparam int CNT_W      = 5;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd5120;
  localparam logic [TOL_W-1:0]    TOL_RESET    = 16'd0;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_TOL    = 1'b1;
  localparam logic REQ_LOAD   = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLAMP, ST_DIFF, ST_MXX, ST_MYY, ST_MRR, ST_MEE, ST_CMP,
    ST_INPEN, ST_INSEL, ST_SQRT, ST_PUSH, ST_MULX, ST_MULY, ST_DIV,
    ST_MOVE, ST_RESP, ST_DONE
  } cbcr_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLAMP, OP_DIFF, OP_MXX, OP_MYY, OP_MRR, OP_MEE, OP_CMP,
    OP_INPEN, OP_INSEL, OP_SQRT, OP_PUSH, OP_MULX, OP_MULY, OP_DIV,
    OP_MOVE, OP_RESP
  } cbcr_op_e;

  typedef struct packed {
    cbcr_op_e op;
    logic     accept;
    logic     out_load;
  } cbcr_cmd_t;

  typedef struct packed {
    logic req_box;
    logic pre_hit;
    logic hit;
    logic at_centre;
  } cbcr_status_t;

endpackage

// ----- src/cbcr_if.sv -----
// Word channels of the resolver: request words in, result words out.
// Widths follow COORD_WIDTH; no package dependency.
interface cbcr_req_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [COORD_WIDTH-1:0] load_x;
  logic signed [COORD_WIDTH-1:0] load_y;
  logic signed [COORD_WIDTH-1:0] load_speed_x;
  logic signed [COORD_WIDTH-1:0] load_vert_speed;
  logic                          load_jumping;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;

  modport source (output valid, req_type, load_x, load_y, load_speed_x, load_vert_speed,
                  load_jumping, box_min_x, box_min_y, box_max_x, box_max_y,
                  input ready);
  modport sink (input valid, req_type, load_x, load_y, load_speed_x, load_vert_speed,
                load_jumping, box_min_x, box_min_y, box_max_x, box_max_y,
                output ready);
endinterface

interface cbcr_rsp_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_x;
  logic signed [COORD_WIDTH-1:0] new_y;
  logic signed [COORD_WIDTH-1:0] new_speed_x;
  logic signed [COORD_WIDTH-1:0] new_vert_speed;
  logic                          new_jumping;
  logic signed [COORD_WIDTH-1:0] ground_level;
  logic                          landed;
  logic                          on_something;

  modport source (output valid, new_x, new_y, new_speed_x, new_vert_speed, new_jumping,
                  ground_level, landed, on_something, input ready);
  modport sink (input valid, new_x, new_y, new_speed_x, new_vert_speed, new_jumping,
                ground_level, landed, on_something, output ready);
endinterface

// ----- src/cbcr_ctrl.sv -----
// Sequencer of the resolver: walks one word through the datapath steps.
// Depends on cbcr_pkg and the assertion macro header.
module cbcr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  cbcr_pkg::cbcr_status_t status_i,
  output cbcr_pkg::cbcr_cmd_t    cmd_o
);
  import cbcr_pkg::*;

  cbcr_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, out_load;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = (status_i.req_box) ? ST_CLAMP : ST_DONE;
      ST_CLAMP: state_d = ST_DIFF;
      ST_DIFF:  state_d = status_i.pre_hit ? ST_MXX : ST_DONE;
      ST_MXX:   state_d = ST_MYY;
      ST_MYY:   state_d = ST_MRR;
      ST_MRR:   state_d = ST_MEE;
      ST_MEE:   state_d = ST_CMP;
      ST_CMP: begin
        if (!status_i.hit) state_d = ST_DONE;
        else if (status_i.at_centre) state_d = ST_INPEN;
        else state_d = ST_SQRT;
      end
      ST_INPEN: state_d = ST_INSEL;
      ST_INSEL: state_d = ST_RESP;
      ST_SQRT:  if (cnt_q == CNT_W'(SQRT_ITERS - 1)) state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CNT_W'(DIV_ITERS - 1)) state_d = ST_MOVE;
      ST_MOVE:  state_d = ST_RESP;
      ST_RESP:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.out_load = out_load;
    case (state_q)
      ST_CLAMP: cmd_o.op = OP_CLAMP;
      ST_DIFF:  cmd_o.op = OP_DIFF;
      ST_MXX:   cmd_o.op = OP_MXX;
      ST_MYY:   cmd_o.op = OP_MYY;
      ST_MRR:   cmd_o.op = OP_MRR;
      ST_MEE:   cmd_o.op = OP_MEE;
      ST_CMP:   cmd_o.op = OP_CMP;
      ST_INPEN: cmd_o.op = OP_INPEN;
      ST_INSEL: cmd_o.op = OP_INSEL;
      ST_SQRT:  cmd_o.op = OP_SQRT;
      ST_PUSH:  cmd_o.op = OP_PUSH;
      ST_MULX:  cmd_o.op = OP_MULX;
      ST_MULY:  cmd_o.op = OP_MULY;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_MOVE:  cmd_o.op = OP_MOVE;
      ST_RESP:  cmd_o.op = OP_RESP;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == ST_SQRT || state_q == ST_DIV) cnt_d = cnt_q + CNT_W'(1);
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `include "circle_box_collision_resolve_top_assert.svh"

  `CBCR_ASSERT(a_div_cnt_range, (state_q == ST_DIV), (cnt_q < CNT_W'(DIV_ITERS)))
  `CBCR_ASSERT_NX(a_load_sets_valid, out_load, out_valid_q)
  `CBCR_ASSERT_NX(a_load_word_short, (accept && !status_i.req_box), (state_q == ST_DONE))
endmodule

// ----- src/cbcr_datapath.sv -----
// Datapath of the resolver: body state, config registers, shared multiplier,
// iterative root and divider lanes, push-out and response logic. Uses cbcr_pkg.
module cbcr_datapath #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [cbcr_pkg::RADIUS_W-1:0]       cfg_wdata_i,
  input  logic                                req_type_i,
  input  logic signed [COORD_WIDTH-1:0]       load_x_i,
  input  logic signed [COORD_WIDTH-1:0]       load_y_i,
  input  logic signed [COORD_WIDTH-1:0]       load_speed_x_i,
  input  logic signed [COORD_WIDTH-1:0]       load_vert_speed_i,
  input  logic                                load_jumping_i,
  input  logic signed [COORD_WIDTH-1:0]       box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0]       box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0]       box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0]       box_max_y_i,
  input  cbcr_pkg::cbcr_cmd_t                 cmd_i,
  output cbcr_pkg::cbcr_status_t              status_o,
  output logic signed [COORD_WIDTH-1:0]       new_x_o,
  output logic signed [COORD_WIDTH-1:0]       new_y_o,
  output logic signed [COORD_WIDTH-1:0]       new_speed_x_o,
  output logic signed [COORD_WIDTH-1:0]       new_vert_speed_o,
  output logic                                new_jumping_o,
  output logic signed [COORD_WIDTH-1:0]       ground_level_o,
  output logic                                landed_o,
  output logic                                on_something_o
);
  import cbcr_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int CW      = (W + 2 > 27) ? W + 2 : 27;
  localparam int PW      = ((W > 28) ? W : 28) + 3;
  localparam int EPS_SHL = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int EPS_SHR = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
  localparam logic signed [PW-1:0] SMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return t[W-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mag(input logic signed [PW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // config and architectural state
  logic [RADIUS_W-1:0]  radius_q;
  logic [TOL_W-1:0]     tol_q;
  logic signed [W-1:0]  body_x_q, body_y_q, speed_x_q, vert_speed_q, ground_q;
  logic                 jumping_q, contact_q, landed_q;
  // box word
  logic signed [W-1:0]  mnx_q, mny_q, mxx_q, mxy_q, cx_q, cy_q;
  // working registers
  logic signed [DXW-1:0] dx_q, dy_q;
  logic [DW-1:0]         dx2_q, dy2_q, rr_q, d2_q, thr_q;
  logic [DW-1:0]         sv_q, sres_q, sbit_q;
  logic [SQW-1:0]        dist_q;
  logic signed [PSW-1:0] push_q;
  logic [NW-1:0]         remx_q, remy_q, dsh_q;
  logic [QW-1:0]         qx_q, qy_q;
  logic                  negx_q, negy_q;
  logic signed [PW-1:0]  pl_q, pr_q, pt_q, pb_q, movx_q, movy_q;
  logic                  down_q, up_q, spos_q, sneg_q;
  // output word
  logic signed [W-1:0]   o_x_q, o_y_q, o_sx_q, o_vs_q, o_gnd_q;
  logic                  o_jmp_q, o_land_q, o_cont_q;

  // combinational helpers
  logic [EPS_W-1:0]      eps;
  logic signed [PW-1:0]  eps_p, r_p;
  logic signed [W-1:0]   cx_c, cy_c;
  logic signed [CW-1:0]  dxw, dyw, adxw, adyw, rpe;
  logic signed [MW-1:0]  ma, mb;
  logic signed [PRW-1:0] prod;
  logic [PRW-1:0]        prod_mag;
  logic [DW-1:0]         ssum;
  logic signed [PW-1:0]  best, mvx, mvy, px, py, py_land;
  logic signed [PW-1:0]  qxs, qys;

  assign eps   = ({{(EPS_W-TOL_W){1'b0}}, tol_q} << EPS_SHL) >> EPS_SHR;
  assign eps_p = PW'(eps);
  assign r_p   = PW'(radius_q);

  always_comb begin
    cx_c = (body_x_q < mxx_q) ? body_x_q : mxx_q;
    if (cx_c < mnx_q) cx_c = mnx_q;
    cy_c = (body_y_q < mxy_q) ? body_y_q : mxy_q;
    if (cy_c < mny_q) cy_c = mny_q;
  end

  assign dxw  = CW'(body_x_q) - CW'(cx_q);
  assign dyw  = CW'(body_y_q) - CW'(cy_q);
  assign adxw = (dxw < 0) ? -dxw : dxw;
  assign adyw = (dyw < 0) ? -dyw : dyw;
  assign rpe  = CW'(radius_q) + CW'(eps);

  // shared multiplier
  always_comb begin
    case (cmd_i.op)
      OP_MXX:  begin ma = MW'(dx_q);     mb = MW'(dx_q);     end
      OP_MYY:  begin ma = MW'(dy_q);     mb = MW'(dy_q);     end
      OP_MRR:  begin ma = MW'(radius_q); mb = MW'(radius_q); end
      OP_MEE:  begin ma = MW'(eps);      mb = MW'(eps);      end
      OP_MULX: begin ma = MW'(dx_q);     mb = MW'(push_q);   end
      OP_MULY: begin ma = MW'(dy_q);     mb = MW'(push_q);   end
      default: begin ma = '0;            mb = '0;            end
    endcase
  end
  assign prod     = ma * mb;
  assign prod_mag = (prod < 0) ? -prod : prod;
  assign ssum     = sres_q + sbit_q;

  // least-penetration pick: left, right, top, bottom; later wins only if strictly smaller
  always_comb begin
    best = pl_q;
    mvx  = pl_q;
    mvy  = '0;
    if (mag(pr_q) < mag(best)) begin best = pr_q; mvx = -pr_q; mvy = '0;    end
    if (mag(pt_q) < mag(best)) begin best = pt_q; mvx = '0;    mvy = pt_q;  end
    if (mag(pb_q) < mag(best)) begin best = pb_q; mvx = '0;    mvy = -pb_q; end
  end

  assign qxs     = PW'(qx_q);
  assign qys     = PW'(qy_q);
  assign px      = PW'(body_x_q) + movx_q;
  assign py      = PW'(body_y_q) + movy_q;
  assign py_land = PW'(mny_q) - r_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= RADIUS_RESET;
      tol_q        <= TOL_RESET;
      body_x_q     <= '0;
      body_y_q     <= '0;
      speed_x_q    <= '0;
      vert_speed_q <= '0;
      ground_q     <= '0;
      jumping_q    <= 1'b0;
      contact_q    <= 1'b0;
      landed_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RADIUS: radius_q <= cfg_wdata_i;
          REG_TOL:    tol_q    <= cfg_wdata_i[TOL_W-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.accept) begin
        landed_q <= 1'b0;
        if (req_type_i == REQ_LOAD) begin
          body_x_q     <= load_x_i;
          body_y_q     <= load_y_i;
          speed_x_q    <= load_speed_x_i;
          vert_speed_q <= load_vert_speed_i;
          jumping_q    <= load_jumping_i;
          contact_q    <= 1'b0;
        end
      end
      if (cmd_i.op == OP_RESP) begin
        body_x_q <= sat(px);
        if (down_q) begin
          body_y_q     <= sat(py_land);
          ground_q     <= sat(py_land);
          vert_speed_q <= '0;
          jumping_q    <= 1'b0;
          landed_q     <= 1'b1;
          contact_q    <= 1'b1;
        end else if (up_q) begin
          body_y_q     <= sat(PW'(mxy_q) + r_p);
          vert_speed_q <= '0;
        end else begin
          body_y_q <= sat(py);
          if ((spos_q && speed_x_q < 0) || (sneg_q && speed_x_q > 0)) speed_x_q <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mnx_q <= box_min_x_i;
      mny_q <= box_min_y_i;
      mxx_q <= box_max_x_i;
      mxy_q <= box_max_y_i;
    end
    case (cmd_i.op)
      OP_CLAMP: begin cx_q <= cx_c; cy_q <= cy_c; end
      OP_DIFF:  begin dx_q <= dxw[DXW-1:0]; dy_q <= dyw[DXW-1:0]; end
      OP_MXX:   dx2_q <= prod[DW-1:0];
      OP_MYY:   dy2_q <= prod[DW-1:0];
      OP_MRR:   rr_q  <= prod[DW-1:0];
      OP_MEE: begin
        d2_q  <= dx2_q + dy2_q;
        thr_q <= rr_q + prod[DW-1:0];
      end
      OP_CMP: begin
        sv_q   <= d2_q;
        sres_q <= '0;
        sbit_q <= DW'(1) << (2 * (SQRT_ITERS - 1));
        down_q <= (dy_q < 0) && ({dy2_q, 2'b00} > (DW + 2)'(d2_q));
        up_q   <= (dy_q > 0) && ({dy2_q, 2'b00} > (DW + 2)'(d2_q));
        spos_q <= (dx_q > 0) && ({dx2_q, 2'b00} > (DW + 2)'(d2_q));
        sneg_q <= (dx_q < 0) && ({dx2_q, 2'b00} > (DW + 2)'(d2_q));
      end
      OP_INPEN: begin
        pl_q <= PW'(mnx_q) - PW'(body_x_q) + r_p;
        pr_q <= PW'(body_x_q) + r_p - PW'(mxx_q);
        pt_q <= PW'(mny_q) - PW'(body_y_q) + r_p;
        pb_q <= PW'(body_y_q) + r_p - PW'(mxy_q);
      end
      OP_INSEL: begin
        movx_q <= mvx;
        movy_q <= mvy;
        down_q <= mvy < -eps_p;
        up_q   <= mvy > eps_p;
        spos_q <= mvx > 0;
        sneg_q <= mvx < 0;
      end
      OP_SQRT: begin
        if (sv_q >= ssum) begin
          sv_q   <= sv_q - ssum;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_PUSH: begin
        dist_q <= sres_q[SQW-1:0];
        push_q <= PSW'(radius_q) - PSW'(sres_q[SQW-1:0]);
      end
      OP_MULX: begin
        remx_q <= prod_mag + NW'(dist_q >> 1);
        negx_q <= prod < 0;
        dsh_q  <= NW'(dist_q) << (DIV_ITERS - 1);
        qx_q   <= '0;
        qy_q   <= '0;
      end
      OP_MULY: begin
        remy_q <= prod_mag + NW'(dist_q >> 1);
        negy_q <= prod < 0;
      end
      OP_DIV: begin
        if (remx_q >= dsh_q) begin
          remx_q <= remx_q - dsh_q;
          qx_q   <= {qx_q[QW-2:0], 1'b1};
        end else begin
          qx_q <= {qx_q[QW-2:0], 1'b0};
        end
        if (remy_q >= dsh_q) begin
          remy_q <= remy_q - dsh_q;
          qy_q   <= {qy_q[QW-2:0], 1'b1};
        end else begin
          qy_q <= {qy_q[QW-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      OP_MOVE: begin
        movx_q <= negx_q ? -qxs : qxs;
        movy_q <= negy_q ? -qys : qys;
      end
      default: ;
    endcase
  end

  // result word, captured from the state committed in earlier cycles
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_x_q    <= body_x_q;
      o_y_q    <= body_y_q;
      o_sx_q   <= speed_x_q;
      o_vs_q   <= vert_speed_q;
      o_jmp_q  <= jumping_q;
      o_gnd_q  <= ground_q;
      o_land_q <= landed_q;
      o_cont_q <= contact_q;
    end
  end

  assign status_o.req_box   = (req_type_i != REQ_LOAD);
  assign status_o.pre_hit   = (adxw < rpe) && (adyw < rpe);
  assign status_o.hit       = d2_q < thr_q;
  assign status_o.at_centre = (dx_q == '0) && (dy_q == '0);

  assign new_x_o          = o_x_q;
  assign new_y_o          = o_y_q;
  assign new_speed_x_o    = o_sx_q;
  assign new_vert_speed_o = o_vs_q;
  assign new_jumping_o    = o_jmp_q;
  assign ground_level_o   = o_gnd_q;
  assign landed_o         = o_land_q;
  assign on_something_o   = o_cont_q;

  `include "circle_box_collision_resolve_top_assert.svh"

  `CBCR_ASSERT(a_div_nonzero, (cmd_i.op == OP_DIV), (dsh_q != '0))
  `CBCR_ASSERT(a_sqrt_bit_live, (cmd_i.op == OP_SQRT), (sbit_q != '0))
  `CBCR_ASSERT(a_dist_nonzero, (cmd_i.op == OP_MULX), (dist_q != '0))
endmodule

// ----- src/circle_box_collision_resolve_top.sv -----
// Circle versus axis-aligned box collision resolver, top level.
// Channels: req_i (sink) takes load and box words, rsp_i (source) returns one result word
// per request word. Config: cfg_we_i / cfg_idx_i / cfg_wdata_i write radius (index 0)
// and tolerance (index 1, Q8.8) in the clock edge where cfg_we_i is high.
// Paths from request accept to result valid:
//   load word                 straight to the done step
//   box missed by quick test, or missed after squared test: straight to the done step
//   centre inside the box     least-penetration pick, then the response step
//   normal push               26 root steps plus 28 divide steps,
//                             the x and y quotients run side by side in two lanes.
// The block works on one word at a time: req_i.ready is high only while idle, since each
// box chains on the body position left by the previous one. The result sits in an output
// register; a stalled receiver holds it, and the finished word after it waits in the
// done step until the register frees up.
// Reset (rst_ni low, async) clears the body state, contact flag and handshake control,
// and restores radius 5120 (20.0) and tolerance 0. Write config only while idle.
module circle_box_collision_resolve_top #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cbcr_pkg::RADIUS_W-1:0] cfg_wdata_i,
  cbcr_req_if.sink                      req_i,
  cbcr_rsp_if.source                    rsp_i
);
  import cbcr_pkg::*;

  cbcr_cmd_t    cmd;
  cbcr_status_t status;

  // sequencer: handshake, step order, iteration count
  cbcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_i.valid),
    .out_ready_i (rsp_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  cbcr_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_i.req_type),
    .load_x_i          (req_i.load_x),
    .load_y_i          (req_i.load_y),
    .load_speed_x_i    (req_i.load_speed_x),
    .load_vert_speed_i (req_i.load_vert_speed),
    .load_jumping_i    (req_i.load_jumping),
    .box_min_x_i       (req_i.box_min_x),
    .box_min_y_i       (req_i.box_min_y),
    .box_max_x_i       (req_i.box_max_x),
    .box_max_y_i       (req_i.box_max_y),
    .cmd_i             (cmd),
    .status_o          (status),
    .new_x_o           (rsp_i.new_x),
    .new_y_o           (rsp_i.new_y),
    .new_speed_x_o     (rsp_i.new_speed_x),
    .new_vert_speed_o  (rsp_i.new_vert_speed),
    .new_jumping_o     (rsp_i.new_jumping),
    .ground_level_o    (rsp_i.ground_level),
    .landed_o          (rsp_i.landed),
    .on_something_o    (rsp_i.on_something)
  );
endmodule
